// ===== rtl/tcls_pkg.sv =====
// Shared types and constants for the three-class landing scheduler.
package tcls_pkg;

    localparam int QUEUE_DEPTH_DEFAULT  = 256;
    localparam int SERVER_COUNT_DEFAULT = 3;

    localparam int NUM_CLASSES = 3;
    localparam int MINUTE_W    = 11;
    localparam int ID_W        = 8;
    localparam int CLASS_W     = 2;
    localparam int KIND_W      = 3;
    localparam int PERIOD_W    = 8;

    localparam logic [MINUTE_W-1:0] DAY_MINUTES = 11'd1440;

    // class codes
    localparam logic [CLASS_W-1:0] CLS_A = 2'd0;
    localparam logic [CLASS_W-1:0] CLS_B = 2'd1;
    localparam logic [CLASS_W-1:0] CLS_C = 2'd2;

    // event kinds
    localparam logic [KIND_W-1:0] EV_SERVED     = 3'd0;
    localparam logic [KIND_W-1:0] EV_PROMOTE_BA = 3'd1;
    localparam logic [KIND_W-1:0] EV_PROMOTE_CB = 3'd2;
    localparam logic [KIND_W-1:0] EV_ADMITTED   = 3'd3;
    localparam logic [KIND_W-1:0] EV_OVERFLOW   = 3'd4;

    // configuration register indexes
    localparam logic [1:0] REG_START_MINUTE    = 2'd0;
    localparam logic [1:0] REG_SERVICE_MINUTES = 2'd1;
    localparam logic [1:0] REG_AGING_PERIOD    = 2'd2;

    localparam logic [MINUTE_W-1:0] START_MINUTE_RESET    = 11'd0;
    localparam logic [PERIOD_W-1:0] SERVICE_MINUTES_RESET = 8'd20;
    localparam logic [PERIOD_W-1:0] AGING_PERIOD_RESET    = 8'd20;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MOD,
        ST_SERVE,
        ST_SERVE_WR,
        ST_AB_CHK,
        ST_AB_WR,
        ST_CB_CHK,
        ST_CB_WR,
        ST_ARRIVE,
        ST_FLUSH
    } state_t;

endpackage

// ===== rtl/tcls_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module tcls_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/three_class_landing_scheduler_core.sv =====
// Top level of the three-class landing scheduler: queues, servers, aging and result stream.
// Each tick runs a bit-serial remainder unit for the aging test, then one state per queue
// access. A new input beat is accepted only in the idle state, once the last tick is done;
// a tick past the end of day only sets the minute and produces no result. Each queue move
// reads its FIFO RAM in a serve or check state, writes in a write state; output stalls hold.
// Reset (rst_n low, asynchronous) empties all queues, frees all servers, clears the minute
// and loads the configuration reset values; the FIFO RAMs themselves are not cleared.
module three_class_landing_scheduler_core #(
    parameter int QUEUE_DEPTH  = tcls_pkg::QUEUE_DEPTH_DEFAULT,
    parameter int SERVER_COUNT = tcls_pkg::SERVER_COUNT_DEFAULT,
    localparam int SRV_W   = (SERVER_COUNT > 1) ? $clog2(SERVER_COUNT) : 1,
    localparam int OUT_BITS = tcls_pkg::KIND_W + tcls_pkg::ID_W + SRV_W + tcls_pkg::MINUTE_W,
    localparam int OUT_W   = ((OUT_BITS + 7) / 8) * 8
) (
    input  logic             clk,
    input  logic             rst_n,
    // configuration port
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [3:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    // arrivals
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [15:0]      s_axis_tdata,   // arrival_id, arrival_class
    input  logic             s_axis_tuser,   // arrival_valid
    // results
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata,   // event_kind, request_id, server_index, minute_of_day
    output logic             m_axis_tlast
);

    localparam int NC   = tcls_pkg::NUM_CLASSES;
    localparam int AW   = $clog2(QUEUE_DEPTH);
    localparam int CW   = $clog2(QUEUE_DEPTH + 1);
    localparam int SW   = CW + 1;
    localparam int MW   = tcls_pkg::MINUTE_W;
    localparam int IW   = tcls_pkg::ID_W;
    localparam int KW   = tcls_pkg::KIND_W;
    localparam int PW   = tcls_pkg::PERIOD_W;
    localparam logic [3:0] MOD_FIRST_BIT = 4'(MW - 1);

    tcls_pkg::state_t state_reg, state_next;

    // configuration
    logic [MW-1:0] start_minute_reg, start_minute_next;
    logic [PW-1:0] service_minutes_reg, service_minutes_next;
    logic [PW-1:0] aging_period_reg, aging_period_next;

    // tick state
    logic [MW-1:0] minute_reg, minute_next;
    logic          started_reg, started_next;
    logic          arr_valid_reg, arr_valid_next;
    logic [IW-1:0] arr_id_reg, arr_id_next;
    logic [1:0]    arr_cls_reg, arr_cls_next;
    logic [PW-1:0] rem_reg, rem_next;
    logic [3:0]    mod_cnt_reg, mod_cnt_next;
    logic [1:0]    sel_cls_reg, sel_cls_next;
    logic [SRV_W-1:0] sel_srv_reg, sel_srv_next;

    // queue and server state
    logic [AW-1:0] head_reg [NC];
    logic [AW-1:0] head_next [NC];
    logic [CW-1:0] cnt_reg [NC];
    logic [CW-1:0] cnt_next [NC];
    logic [MW-1:0] free_at_reg [SERVER_COUNT];
    logic [MW-1:0] free_at_next [SERVER_COUNT];

    // one held result, so the last flag can be set once the tick is known to be done
    logic          pend_valid_reg, pend_valid_next;
    logic [KW-1:0] pend_kind_reg, pend_kind_next;
    logic [IW-1:0] pend_id_reg, pend_id_next;
    logic [SRV_W-1:0] pend_srv_reg, pend_srv_next;

    // output register
    logic          out_valid_reg, out_valid_next;
    logic [KW-1:0] out_kind_reg, out_kind_next;
    logic [IW-1:0] out_id_reg, out_id_next;
    logic [SRV_W-1:0] out_srv_reg, out_srv_next;
    logic [MW-1:0] out_minute_reg, out_minute_next;
    logic          out_last_reg, out_last_next;

    // FIFO RAM ports
    logic [NC-1:0] ram_we;
    logic [NC-1:0] ram_re;
    logic [IW-1:0] ram_wdata;
    logic [IW-1:0] ram_rdata [NC];
    logic [AW-1:0] tail [NC];
    logic [SW-1:0] tail_sum [NC];

    logic [NC-1:0] q_empty;
    logic [NC-1:0] q_full;
    logic [SERVER_COUNT-1:0] srv_free;

    logic          cfg_write;
    logic          out_free;
    logic          can_emit;
    logic          aging_hit;
    logic [MW-1:0] tick_minute;
    logic [PW:0]   rem_shift;
    logic          cls_found;
    logic [1:0]    cls_pick;
    logic          srv_found;
    logic [SRV_W-1:0] srv_pick;
    logic [IW-1:0] serve_id;
    logic          arr_fits;

    logic          emit_en;
    logic [KW-1:0] emit_kind;
    logic [IW-1:0] emit_id;
    logic [SRV_W-1:0] emit_srv;
    logic          flush_en;
    logic          pop_en;
    logic [1:0]    pop_cls;
    logic          push_en;
    logic [1:0]    push_cls;
    logic          srv_take;

    genvar g;
    generate
        for (g = 0; g < NC; g++)
        begin : g_fifo
            tcls_ram #(
                .WIDTH(IW),
                .DEPTH(QUEUE_DEPTH)
            ) u_ram (
                .clk    (clk),
                .wr_en  (ram_we[g]),
                .wr_addr(tail[g]),
                .wr_data(ram_wdata),
                .rd_en  (ram_re[g]),
                .rd_addr(head_reg[g]),
                .rd_data(ram_rdata[g])
            );

            assign tail_sum[g] = SW'(head_reg[g]) + SW'(cnt_reg[g]);
            assign tail[g]     = (tail_sum[g] >= SW'(QUEUE_DEPTH))
                               ? AW'(tail_sum[g] - SW'(QUEUE_DEPTH)) : AW'(tail_sum[g]);
            assign q_empty[g]  = (cnt_reg[g] == '0);
            assign q_full[g]   = (cnt_reg[g] >= CW'(QUEUE_DEPTH));
        end
        for (g = 0; g < SERVER_COUNT; g++)
        begin : g_srv
            assign srv_free[g] = (free_at_reg[g] <= minute_reg);
        end
    endgenerate

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        case (paddr[3:2])
            tcls_pkg::REG_START_MINUTE:    prdata = 32'(start_minute_reg);
            tcls_pkg::REG_SERVICE_MINUTES: prdata = 32'(service_minutes_reg);
            tcls_pkg::REG_AGING_PERIOD:    prdata = 32'(aging_period_reg);
            default:                       prdata = 32'd0;
        endcase
    end

    assign s_axis_tready = (state_reg == tcls_pkg::ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_W'({out_minute_reg, out_srv_reg, out_id_reg, out_kind_reg});
    assign m_axis_tlast  = out_last_reg;

    assign out_free  = !out_valid_reg || m_axis_tready;
    assign can_emit  = !pend_valid_reg || out_free;
    assign aging_hit = (aging_period_reg != '0) && (rem_reg == '0);
    assign rem_shift = {rem_reg, minute_reg[mod_cnt_reg]};

    always_comb
    begin
        if (!started_reg)
        begin
            tick_minute = (start_minute_reg > tcls_pkg::DAY_MINUTES)
                        ? tcls_pkg::DAY_MINUTES : start_minute_reg;
        end
        else if (minute_reg < tcls_pkg::DAY_MINUTES)
        begin
            tick_minute = minute_reg + MW'(1);
        end
        else
        begin
            tick_minute = minute_reg;
        end
    end

    // highest-priority (lowest-code) non-empty class, lowest free server, selected read data, arrival room
    always_comb
    begin
        cls_found = 1'b0;
        cls_pick  = tcls_pkg::CLS_A;
        for (int k = NC - 1; k >= 0; k--)
        begin
            if (!q_empty[k])
            begin
                cls_found = 1'b1;
                cls_pick  = 2'(k);
            end
        end
        srv_found = 1'b0;
        srv_pick  = '0;
        for (int s = SERVER_COUNT - 1; s >= 0; s--)
        begin
            if (srv_free[s])
            begin
                srv_found = 1'b1;
                srv_pick  = SRV_W'(s);
            end
        end
        serve_id = '0;
        arr_fits = 1'b0;
        for (int k = 0; k < NC; k++)
        begin
            if (sel_cls_reg == 2'(k))
            begin
                serve_id = ram_rdata[k];
            end
            if (arr_cls_reg == 2'(k) && !q_full[k])
            begin
                arr_fits = 1'b1;
            end
        end
    end

    // next state and datapath control
    always_comb
    begin
        state_next           = state_reg;
        start_minute_next    = start_minute_reg;
        service_minutes_next = service_minutes_reg;
        aging_period_next    = aging_period_reg;
        minute_next          = minute_reg;
        started_next         = started_reg;
        arr_valid_next       = arr_valid_reg;
        arr_id_next          = arr_id_reg;
        arr_cls_next         = arr_cls_reg;
        rem_next             = rem_reg;
        mod_cnt_next         = mod_cnt_reg;
        sel_cls_next         = sel_cls_reg;
        sel_srv_next         = sel_srv_reg;
        pend_valid_next      = pend_valid_reg;
        pend_kind_next       = pend_kind_reg;
        pend_id_next         = pend_id_reg;
        pend_srv_next        = pend_srv_reg;
        out_valid_next       = out_valid_reg && !m_axis_tready;
        out_kind_next        = out_kind_reg;
        out_id_next          = out_id_reg;
        out_srv_next         = out_srv_reg;
        out_minute_next      = out_minute_reg;
        out_last_next        = out_last_reg;
        ram_re               = '0;
        ram_wdata            = '0;
        emit_en              = 1'b0;
        emit_kind            = tcls_pkg::EV_SERVED;
        emit_id              = '0;
        emit_srv             = '0;
        flush_en             = 1'b0;
        pop_en               = 1'b0;
        pop_cls              = tcls_pkg::CLS_A;
        push_en              = 1'b0;
        push_cls             = tcls_pkg::CLS_A;
        srv_take             = 1'b0;

        if (cfg_write)
        begin
            case (paddr[3:2])
                tcls_pkg::REG_START_MINUTE:    start_minute_next    = pwdata[MW-1:0];
                tcls_pkg::REG_SERVICE_MINUTES: service_minutes_next = pwdata[PW-1:0];
                tcls_pkg::REG_AGING_PERIOD:    aging_period_next    = pwdata[PW-1:0];
                default:                       ;
            endcase
        end

        case (state_reg)
            tcls_pkg::ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    started_next   = 1'b1;
                    minute_next    = tick_minute;
                    arr_valid_next = s_axis_tuser;
                    arr_id_next    = s_axis_tdata[IW-1:0];
                    arr_cls_next   = s_axis_tdata[IW+1:IW];
                    rem_next       = '0;
                    mod_cnt_next   = MOD_FIRST_BIT;
                    if (tick_minute < tcls_pkg::DAY_MINUTES)
                    begin
                        state_next = tcls_pkg::ST_MOD;
                    end
                end
            end
            tcls_pkg::ST_MOD:
            begin
                // one restoring-remainder step per cycle, minute MSB first
                if (rem_shift >= {1'b0, aging_period_reg})
                begin
                    rem_next = PW'(rem_shift - {1'b0, aging_period_reg});
                end
                else
                begin
                    rem_next = rem_shift[PW-1:0];
                end
                mod_cnt_next = mod_cnt_reg - 4'd1;
                if (mod_cnt_reg == '0)
                begin
                    state_next = tcls_pkg::ST_SERVE;
                end
            end
            tcls_pkg::ST_SERVE:
            begin
                if (cls_found && srv_found)
                begin
                    ram_re[cls_pick] = 1'b1;
                    sel_cls_next     = cls_pick;
                    sel_srv_next     = srv_pick;
                    state_next       = tcls_pkg::ST_SERVE_WR;
                end
                else
                begin
                    state_next = tcls_pkg::ST_AB_CHK;
                end
            end
            tcls_pkg::ST_SERVE_WR:
            begin
                if (can_emit)
                begin
                    emit_en    = 1'b1;
                    emit_kind  = tcls_pkg::EV_SERVED;
                    emit_id    = serve_id;
                    emit_srv   = sel_srv_reg;
                    pop_en     = 1'b1;
                    pop_cls    = sel_cls_reg;
                    srv_take   = 1'b1;
                    state_next = tcls_pkg::ST_AB_CHK;
                end
            end
            tcls_pkg::ST_AB_CHK:
            begin
                if (aging_hit && !q_empty[tcls_pkg::CLS_B] && !q_full[tcls_pkg::CLS_A])
                begin
                    ram_re[tcls_pkg::CLS_B] = 1'b1;
                    state_next = tcls_pkg::ST_AB_WR;
                end
                else
                begin
                    state_next = tcls_pkg::ST_CB_CHK;
                end
            end
            tcls_pkg::ST_AB_WR:
            begin
                if (can_emit)
                begin
                    emit_en    = 1'b1;
                    emit_kind  = tcls_pkg::EV_PROMOTE_BA;
                    emit_id    = ram_rdata[tcls_pkg::CLS_B];
                    pop_en     = 1'b1;
                    pop_cls    = tcls_pkg::CLS_B;
                    push_en    = 1'b1;
                    push_cls   = tcls_pkg::CLS_A;
                    ram_wdata  = ram_rdata[tcls_pkg::CLS_B];
                    state_next = tcls_pkg::ST_CB_CHK;
                end
            end
            tcls_pkg::ST_CB_CHK:
            begin
                if (aging_hit && !q_empty[tcls_pkg::CLS_C] && !q_full[tcls_pkg::CLS_B])
                begin
                    ram_re[tcls_pkg::CLS_C] = 1'b1;
                    state_next = tcls_pkg::ST_CB_WR;
                end
                else
                begin
                    state_next = tcls_pkg::ST_ARRIVE;
                end
            end
            tcls_pkg::ST_CB_WR:
            begin
                if (can_emit)
                begin
                    emit_en    = 1'b1;
                    emit_kind  = tcls_pkg::EV_PROMOTE_CB;
                    emit_id    = ram_rdata[tcls_pkg::CLS_C];
                    pop_en     = 1'b1;
                    pop_cls    = tcls_pkg::CLS_C;
                    push_en    = 1'b1;
                    push_cls   = tcls_pkg::CLS_B;
                    ram_wdata  = ram_rdata[tcls_pkg::CLS_C];
                    state_next = tcls_pkg::ST_ARRIVE;
                end
            end
            tcls_pkg::ST_ARRIVE:
            begin
                if (!arr_valid_reg)
                begin
                    state_next = tcls_pkg::ST_FLUSH;
                end
                else if (can_emit)
                begin
                    emit_en = 1'b1;
                    emit_id = arr_id_reg;
                    if (arr_fits)
                    begin
                        emit_kind = tcls_pkg::EV_ADMITTED;
                        push_en   = 1'b1;
                        push_cls  = arr_cls_reg;
                        ram_wdata = arr_id_reg;
                    end
                    else
                    begin
                        emit_kind = tcls_pkg::EV_OVERFLOW;
                    end
                    state_next = tcls_pkg::ST_FLUSH;
                end
            end
            tcls_pkg::ST_FLUSH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = tcls_pkg::ST_IDLE;
                end
                else if (out_free)
                begin
                    flush_en        = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = tcls_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tcls_pkg::ST_IDLE;
            end
        endcase

        // a new result pushes the held one out with last clear
        if (emit_en)
        begin
            pend_valid_next = 1'b1;
            pend_kind_next  = emit_kind;
            pend_id_next    = emit_id;
            pend_srv_next   = emit_srv;
        end
        if ((emit_en && pend_valid_reg) || flush_en)
        begin
            out_valid_next  = 1'b1;
            out_kind_next   = pend_kind_reg;
            out_id_next     = pend_id_reg;
            out_srv_next    = pend_srv_reg;
            out_minute_next = minute_reg;
            out_last_next   = flush_en;
        end

        for (int k = 0; k < NC; k++)
        begin
            head_next[k] = head_reg[k];
            cnt_next[k]  = cnt_reg[k];
            ram_we[k]    = push_en && (push_cls == 2'(k));
            if (pop_en && (pop_cls == 2'(k)))
            begin
                head_next[k] = (head_reg[k] == AW'(QUEUE_DEPTH - 1))
                             ? '0 : head_reg[k] + AW'(1);
                cnt_next[k]  = cnt_reg[k] - CW'(1);
            end
            if (ram_we[k])
            begin
                cnt_next[k] = cnt_next[k] + CW'(1);
            end
        end

        for (int s = 0; s < SERVER_COUNT; s++)
        begin
            free_at_next[s] = free_at_reg[s];
            if (srv_take && (sel_srv_reg == SRV_W'(s)))
            begin
                free_at_next[s] = minute_reg + MW'(service_minutes_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= tcls_pkg::ST_IDLE;
            start_minute_reg    <= tcls_pkg::START_MINUTE_RESET;
            service_minutes_reg <= tcls_pkg::SERVICE_MINUTES_RESET;
            aging_period_reg    <= tcls_pkg::AGING_PERIOD_RESET;
            minute_reg          <= '0;
            started_reg         <= 1'b0;
            mod_cnt_reg         <= '0;
            pend_valid_reg      <= 1'b0;
            out_valid_reg       <= 1'b0;
            for (int k = 0; k < NC; k++)
            begin
                head_reg[k] <= '0;
                cnt_reg[k]  <= '0;
            end
            for (int s = 0; s < SERVER_COUNT; s++)
            begin
                free_at_reg[s] <= '0;
            end
        end
        else
        begin
            state_reg           <= state_next;
            start_minute_reg    <= start_minute_next;
            service_minutes_reg <= service_minutes_next;
            aging_period_reg    <= aging_period_next;
            minute_reg          <= minute_next;
            started_reg         <= started_next;
            mod_cnt_reg         <= mod_cnt_next;
            pend_valid_reg      <= pend_valid_next;
            out_valid_reg       <= out_valid_next;
            for (int k = 0; k < NC; k++)
            begin
                head_reg[k] <= head_next[k];
                cnt_reg[k]  <= cnt_next[k];
            end
            for (int s = 0; s < SERVER_COUNT; s++)
            begin
                free_at_reg[s] <= free_at_next[s];
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        arr_valid_reg  <= arr_valid_next;
        arr_id_reg     <= arr_id_next;
        arr_cls_reg    <= arr_cls_next;
        rem_reg        <= rem_next;
        sel_cls_reg    <= sel_cls_next;
        sel_srv_reg    <= sel_srv_next;
        pend_kind_reg  <= pend_kind_next;
        pend_id_reg    <= pend_id_next;
        pend_srv_reg   <= pend_srv_next;
        out_kind_reg   <= out_kind_next;
        out_id_reg     <= out_id_next;
        out_srv_reg    <= out_srv_next;
        out_minute_reg <= out_minute_next;
        out_last_reg   <= out_last_next;
    end

    // no held result may survive into the next tick
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tcls_pkg::ST_IDLE) |-> !pend_valid_reg)
        else $error("held result left over at end of tick");

    // queue occupancy stays within the RAM depth
    assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg[0] <= CW'(QUEUE_DEPTH)) && (cnt_reg[1] <= CW'(QUEUE_DEPTH))
        && (cnt_reg[2] <= CW'(QUEUE_DEPTH)))
        else $error("queue count above depth");

    // a served request goes to a server that was free at this minute
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tcls_pkg::ST_SERVE_WR) |-> (free_at_reg[sel_srv_reg] <= minute_reg))
        else $error("request assigned to a busy server");

    // a write back into a queue always lands in a queue with room
    assert property (@(posedge clk) disable iff (!rst_n)
        push_en |-> !q_full[push_cls])
        else $error("push into a full queue");

endmodule
